>>> hdl/amf0_pkg.sv
// Shared types and constants for the AMF0 stream tokenizer.
package amf0_pkg;

	// Deepest object nesting accepted; an object opened at depth 15 is a depth error.
	localparam int MAX_DEPTH = 15;
	localparam logic [3:0] DEPTH_LIMIT = (MAX_DEPTH > 15) ? 4'd15 : 4'(MAX_DEPTH);

	// Command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	// AMF0 type markers
	localparam logic [4:0] T_NUMBER   = 5'd0;
	localparam logic [4:0] T_BOOLEAN  = 5'd1;
	localparam logic [4:0] T_STRING   = 5'd2;
	localparam logic [4:0] T_OBJECT   = 5'd3;
	localparam logic [4:0] T_NULL     = 5'd5;
	localparam logic [4:0] T_UNDEF    = 5'd6;
	localparam logic [4:0] T_REF      = 5'd7;
	localparam logic [4:0] T_OBJ_END  = 5'd9;
	localparam logic [4:0] T_DATE     = 5'd11;
	localparam logic [4:0] T_LONG_STR = 5'd12;
	localparam logic [4:0] T_UNSUP    = 5'd13;
	localparam logic [4:0] T_XML      = 5'd15;
	localparam logic [4:0] T_LAST     = 5'd17;

	// Byte roles
	localparam logic [2:0] ROLE_MARKER   = 3'd0;
	localparam logic [2:0] ROLE_NAME_LEN = 3'd1;
	localparam logic [2:0] ROLE_NAME     = 3'd2;
	localparam logic [2:0] ROLE_VAL_LEN  = 3'd3;
	localparam logic [2:0] ROLE_PAYLOAD  = 3'd4;
	localparam logic [2:0] ROLE_ERROR    = 3'd5;

	// Error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_UNSUP = 2'd1;
	localparam logic [1:0] ERR_END   = 2'd2;
	localparam logic [1:0] ERR_DEEP  = 2'd3;

	// What a byte would start if it were a type marker
	typedef enum logic [2:0] {
		K_FIXED,
		K_LEN,
		K_OBJ,
		K_END,
		K_VOID,
		K_UNSUP
	} kind_t;

	// Classified input beat, front to back
	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic [4:0] mtype;
		kind_t      kind;
		logic [3:0] init_left;
	} cmd_t;

	// Result beat
	typedef struct packed {
		logic [2:0]  role;
		logic [4:0]  vtype;
		logic [3:0]  depth;
		logic [7:0]  data;
		logic        done;
		logic [63:0] bits;
		logic [15:0] zone;
		logic [1:0]  err;
	} res_t;

endpackage

>>> hdl/amf0_front.sv
// Front stage: accepts input beats and classifies each byte as a would-be type marker.
module amf0_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        data_byte,
	input  logic              message_start,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output amf0_pkg::cmd_t    cmd
);

	logic           valid_s1;
	amf0_pkg::cmd_t cmd_s1;
	amf0_pkg::cmd_t cls;
	logic           in_ready;

	always_comb begin
		cls.data      = data_byte;
		cls.start     = message_start;
		cls.mtype     = (data_byte <= 8'(amf0_pkg::T_LAST)) ? data_byte[4:0] : amf0_pkg::T_UNSUP;
		cls.kind      = amf0_pkg::K_UNSUP;
		cls.init_left = 4'd0;
		unique case (cls.mtype) inside
			amf0_pkg::T_NUMBER: begin
				cls.kind      = amf0_pkg::K_FIXED;
				cls.init_left = 4'd8;
			end
			amf0_pkg::T_BOOLEAN: begin
				cls.kind      = amf0_pkg::K_FIXED;
				cls.init_left = 4'd1;
			end
			amf0_pkg::T_REF: begin
				cls.kind      = amf0_pkg::K_FIXED;
				cls.init_left = 4'd2;
			end
			amf0_pkg::T_DATE: begin
				cls.kind      = amf0_pkg::K_FIXED;
				cls.init_left = 4'd10;
			end
			amf0_pkg::T_STRING: begin
				cls.kind      = amf0_pkg::K_LEN;
				cls.init_left = 4'd2;
			end
			amf0_pkg::T_LONG_STR, amf0_pkg::T_XML: begin
				cls.kind      = amf0_pkg::K_LEN;
				cls.init_left = 4'd4;
			end
			amf0_pkg::T_OBJECT: cls.kind = amf0_pkg::K_OBJ;
			amf0_pkg::T_OBJ_END: cls.kind = amf0_pkg::K_END;
			amf0_pkg::T_NULL, amf0_pkg::T_UNDEF: cls.kind = amf0_pkg::K_VOID;
			default: cls.kind = amf0_pkg::K_UNSUP;
		endcase
	end

	assign in_ready  = !valid_s1 || cmd_ready;
	assign full      = !in_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && in_ready) begin
			cmd_s1 <= cls;
		end
	end

endmodule

>>> hdl/amf0_cmd_queue.sv
// Short FIFO of classified beats between front and back.
module amf0_cmd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  amf0_pkg::cmd_t    wr_cmd,
	output logic              rd_valid,
	input  logic              rd_take,
	output amf0_pkg::cmd_t    rd_cmd
);

	amf0_pkg::cmd_t             mem_q [amf0_pkg::QDEPTH];
	logic [amf0_pkg::QAW-1:0]   wr_ptr_q;
	logic [amf0_pkg::QAW-1:0]   rd_ptr_q;
	logic [amf0_pkg::QAW:0]     count_q;
	logic                       do_wr;
	logic                       do_rd;

	assign wr_ready = (count_q != (amf0_pkg::QAW+1)'(amf0_pkg::QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_take && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

>>> hdl/amf0_back.sv
// Back end: AMF0 parse state machine and two-entry result buffer.
module amf0_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_take,
	input  amf0_pkg::cmd_t    cmd,
	output logic              empty,
	input  logic              pop,
	output amf0_pkg::res_t    res
);

	typedef enum logic [3:0] {
		PH_MARKER,
		PH_NLEN_HI,
		PH_NLEN_LO,
		PH_NAME,
		PH_FIXED,
		PH_LEN,
		PH_STR,
		PH_ERR_UNSUP,
		PH_ERR_END,
		PH_ERR_DEEP
	} phase_t;

	phase_t      ph_q, ph_e, ph_n;
	logic [4:0]  ct_q, ct_e, ct_n;
	logic [31:0] bl_q, bl_e, bl_n, bl_dec;
	logic [63:0] g_q, g_e, g_n;
	logic [3:0]  d_q, d_e, d_n;
	logic [15:0] z_q, z_e, z_n;
	logic [2:0]  role;
	logic [1:0]  err;
	logic        done;
	logic        last;
	logic [7:0]  b;

	amf0_pkg::res_t obuf_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     ocnt_q;
	logic           pop_fire;

	assign cmd_take = cmd_valid && (ocnt_q != 2'd2);
	assign pop_fire = pop && (ocnt_q != 2'd0);
	assign empty    = (ocnt_q == 2'd0);
	assign res      = obuf_q[rd_ptr_q];
	assign b        = cmd.data;

	// Message start restarts from the reset state with this byte.
	always_comb begin
		ph_e = cmd.start ? PH_MARKER : ph_q;
		ct_e = cmd.start ? 5'd0 : ct_q;
		bl_e = cmd.start ? 32'd0 : bl_q;
		g_e  = cmd.start ? 64'd0 : g_q;
		d_e  = cmd.start ? 4'd0 : d_q;
		z_e  = cmd.start ? 16'd0 : z_q;
	end

	assign bl_dec = (bl_e != 32'd0) ? bl_e - 32'd1 : 32'd0;
	assign last   = (bl_e[31:1] == 31'd0);

	always_comb begin
		ph_n = ph_e;
		ct_n = ct_e;
		bl_n = bl_e;
		g_n  = g_e;
		d_n  = d_e;
		z_n  = z_e;
		role = amf0_pkg::ROLE_ERROR;
		err  = amf0_pkg::ERR_NONE;
		done = 1'b0;
		unique case (ph_e)
			PH_MARKER: begin
				role = amf0_pkg::ROLE_MARKER;
				g_n  = 64'd0;
				z_n  = 16'd0;
				ct_n = cmd.mtype;
				unique case (cmd.kind)
					amf0_pkg::K_FIXED: begin
						bl_n = {28'd0, cmd.init_left};
						ph_n = PH_FIXED;
					end
					amf0_pkg::K_LEN: begin
						bl_n = {28'd0, cmd.init_left};
						ph_n = PH_LEN;
					end
					amf0_pkg::K_OBJ: begin
						if (d_e >= amf0_pkg::DEPTH_LIMIT) begin
							ph_n = PH_ERR_DEEP;
							role = amf0_pkg::ROLE_ERROR;
							err  = amf0_pkg::ERR_DEEP;
						end else begin
							d_n  = d_e + 4'd1;
							done = 1'b1;
							ph_n = PH_NLEN_HI;
						end
					end
					amf0_pkg::K_END: begin
						if (d_e == 4'd0) begin
							ph_n = PH_ERR_END;
							role = amf0_pkg::ROLE_ERROR;
							err  = amf0_pkg::ERR_END;
						end else begin
							d_n  = d_e - 4'd1;
							done = 1'b1;
							ph_n = (d_e != 4'd1) ? PH_NLEN_HI : PH_MARKER;
						end
					end
					amf0_pkg::K_VOID: begin
						done = 1'b1;
						ph_n = (d_e != 4'd0) ? PH_NLEN_HI : PH_MARKER;
					end
					default: begin
						ph_n = PH_ERR_UNSUP;
						role = amf0_pkg::ROLE_ERROR;
						err  = amf0_pkg::ERR_UNSUP;
					end
				endcase
			end
			PH_NLEN_HI: begin
				role = amf0_pkg::ROLE_NAME_LEN;
				ct_n = amf0_pkg::T_OBJECT;
				g_n  = {56'd0, b};
				ph_n = PH_NLEN_LO;
			end
			PH_NLEN_LO: begin
				role = amf0_pkg::ROLE_NAME_LEN;
				ct_n = amf0_pkg::T_OBJECT;
				g_n  = {48'd0, g_e[7:0], b};
				done = 1'b1;
				if ({g_e[7:0], b} == 16'd0) begin
					ph_n = PH_MARKER;
				end else begin
					bl_n = {16'd0, g_e[7:0], b};
					ph_n = PH_NAME;
				end
			end
			PH_NAME: begin
				role = amf0_pkg::ROLE_NAME;
				ct_n = amf0_pkg::T_OBJECT;
				bl_n = bl_dec;
				if (last) ph_n = PH_MARKER;
			end
			PH_FIXED: begin
				role = amf0_pkg::ROLE_PAYLOAD;
				// last two date bytes are the timezone
				if (ct_e == amf0_pkg::T_DATE && bl_e <= 32'd2) z_n = {z_e[7:0], b};
				else g_n = {g_e[55:0], b};
				bl_n = bl_dec;
				if (last) begin
					done = 1'b1;
					ph_n = (d_e != 4'd0) ? PH_NLEN_HI : PH_MARKER;
				end
			end
			PH_LEN: begin
				role = amf0_pkg::ROLE_VAL_LEN;
				g_n  = {g_e[55:0], b};
				bl_n = bl_dec;
				if (last) begin
					bl_n = {g_e[23:0], b};
					if ({g_e[23:0], b} == 32'd0) begin
						done = 1'b1;
						ph_n = (d_e != 4'd0) ? PH_NLEN_HI : PH_MARKER;
					end else begin
						ph_n = PH_STR;
					end
				end
			end
			PH_STR: begin
				role = amf0_pkg::ROLE_PAYLOAD;
				bl_n = bl_dec;
				if (last) begin
					done = 1'b1;
					ph_n = (d_e != 4'd0) ? PH_NLEN_HI : PH_MARKER;
				end
			end
			PH_ERR_UNSUP: err = amf0_pkg::ERR_UNSUP;
			PH_ERR_END: err = amf0_pkg::ERR_END;
			PH_ERR_DEEP: err = amf0_pkg::ERR_DEEP;
			default: err = amf0_pkg::ERR_DEEP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= PH_MARKER;
			ct_q     <= 5'd0;
			bl_q     <= 32'd0;
			g_q      <= 64'd0;
			d_q      <= 4'd0;
			z_q      <= 16'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			ocnt_q   <= 2'd0;
		end else begin
			if (cmd_take) begin
				ph_q     <= ph_n;
				ct_q     <= ct_n;
				bl_q     <= bl_n;
				g_q      <= g_n;
				d_q      <= d_n;
				z_q      <= z_n;
				wr_ptr_q <= !wr_ptr_q;
				obuf_q[wr_ptr_q] <= '{role: role, vtype: ct_n, depth: d_n, data: b,
					done: done, bits: g_n, zone: z_n, err: err};
			end
			if (pop_fire) rd_ptr_q <= !rd_ptr_q;
			if (cmd_take && !pop_fire) ocnt_q <= ocnt_q + 2'd1;
			else if (pop_fire && !cmd_take) ocnt_q <= ocnt_q - 2'd1;
		end
	end

endmodule

>>> hdl/amf0_stream_tokenizer.sv
// Top level of the AMF0 stream tokenizer: front classifier, command queue, parse back end.
//
// Byte-serial AMF0 tokenizer. Push one message byte per beat (data_byte, with
// message_start high on the first byte of a message); pop one result beat per
// byte, in order, telling the byte's role, the value type in progress, object
// depth, the assembled payload bits (number, boolean, reference, lengths, date
// timestamp), the date timezone, and an error code. After an error every byte
// reads as errored with the same code until message_start. The block sustains
// one byte per clock cycle while results are popped; the parse state update in
// the back end is the loop that sets the rate. A result passes the front
// register, then a write into the four-beat command queue, then a write into
// the two-beat result buffer before it reaches the output ports. Input and
// output stall independently: full rises only once the front register, the
// command queue and the result buffer are all occupied.
module amf0_stream_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        message_start,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  byte_role,
	output logic [4:0]  value_type,
	output logic [3:0]  nest_depth,
	output logic [7:0]  data_out,
	output logic        value_done,
	output logic [63:0] value_bits,
	output logic signed [15:0] time_zone,
	output logic [1:0]  error_code
);

	logic           f_valid;
	logic           f_ready;
	amf0_pkg::cmd_t f_cmd;
	logic           q_valid;
	logic           q_take;
	amf0_pkg::cmd_t q_cmd;
	amf0_pkg::res_t res;

	amf0_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.message_start(message_start),
		.cmd_valid    (f_valid),
		.cmd_ready    (f_ready),
		.cmd          (f_cmd)
	);

	amf0_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_cmd  (f_cmd),
		.rd_valid(q_valid),
		.rd_take (q_take),
		.rd_cmd  (q_cmd)
	);

	amf0_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_valid),
		.cmd_take (q_take),
		.cmd      (q_cmd),
		.empty    (empty),
		.pop      (pop),
		.res      (res)
	);

	// Result beat fields
	assign byte_role  = res.role;
	assign value_type = res.vtype;
	assign nest_depth = res.depth;
	assign data_out   = res.data;
	assign value_done = res.done;
	assign value_bits = res.bits;
	assign time_zone  = res.zone;
	assign error_code = res.err;

endmodule
